### src/pcw_pkg.sv
package pcw_pkg;

  localparam int PCW_OFFSET_BITS = 32;
  localparam int PCW_TDATA_W     = 104;

  localparam logic [7:0] PNG_MAGIC [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                           8'h0D, 8'h0A, 8'h1A, 8'h0A};

  localparam logic [31:0] TAG_IHDR = 32'h4948_4452;
  localparam logic [31:0] TAG_IDAT = 32'h4944_4154;
  localparam logic [31:0] TAG_IEND = 32'h4945_4E44;

  localparam logic [2:0] KIND_STATUS = 3'd0;
  localparam logic [2:0] KIND_IHDR   = 3'd1;
  localparam logic [2:0] KIND_IDAT   = 3'd2;
  localparam logic [2:0] KIND_IEND   = 3'd3;
  localparam logic [2:0] KIND_OTHER  = 3'd4;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_SIGNATURE = 2'd1;
  localparam logic [1:0] ERR_HEADER    = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED = 2'd3;

  typedef struct packed {
    logic [2:0]  chunk_kind;
    logic [31:0] chunk_offset;
    logic [31:0] chunk_length;
    logic [31:0] chunk_crc;
    logic        signature_good;
    logic        header_good;
    logic        image_data_seen;
    logic        end_chunk_seen;
    logic [1:0]  error_code;
    logic        stream_done;
  } pcw_result_t;

  function automatic logic [2:0] kind_of(input logic [31:0] tag);
    logic [2:0] k;
    if (tag == TAG_IHDR) begin
      k = KIND_IHDR;
    end else if (tag == TAG_IDAT) begin
      k = KIND_IDAT;
    end else if (tag == TAG_IEND) begin
      k = KIND_IEND;
    end else begin
      k = KIND_OTHER;
    end
    return k;
  endfunction

endpackage

### src/png_chunk_walker_core.sv
// Walks a PNG file presented one byte per item on the input stream. The
// eight signature bytes are checked, then each chunk's length, type, data
// and stored CRC are taken in turn; the CRC is reported but not verified.
// One result item follows each chunk's last CRC byte, and the byte marked
// with tlast always gives a final status item, after which the block is
// back at the start of a new file. A bad signature or a first chunk not
// named IHDR halts the walk until the last byte, which reports the error.
// The block takes one byte in every cycle while its skid entry is empty;
// each result is registered into a two-entry output buffer, which lets input
// bytes keep flowing while one result waits to be taken.
module png_chunk_walker_core
  import pcw_pkg::*;
#(
  parameter int OFFSET_BITS = PCW_OFFSET_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // data_byte
  input  logic                   in_tlast,   // end_of_file
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // chunk_offset[31:0], chunk_length[63:32], chunk_crc[95:64],
  // signature_good[96], header_good[97], image_data_seen[98],
  // end_chunk_seen[99], error_code[101:100], zero padding[103:102]
  output logic [PCW_TDATA_W-1:0] out_tdata,
  output logic [2:0]             out_tuser,  // chunk_kind
  output logic                   out_tlast   // stream_done
);

  typedef enum logic [2:0] {
    PH_SIG, PH_LEN, PH_TYPE, PH_DATA, PH_CRC, PH_HALT
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [31:0]            cnt_r, cnt_nxt;
  logic [31:0]            len_r, len_nxt;
  logic [31:0]            type_r, type_nxt;
  logic [31:0]            crc_r, crc_nxt;
  logic                   sig_good_r, sig_good_nxt;
  logic                   hdr_good_r, hdr_good_nxt;
  logic                   idat_r, idat_nxt;
  logic                   iend_r, iend_nxt;
  logic                   pending_r, pending_nxt;
  logic                   mismatch_r, mismatch_nxt;

  logic                   acc;
  logic                   emit;
  pcw_result_t            res;
  pcw_result_t            out_r;
  pcw_result_t            skid_r;
  logic                   out_v_r;
  logic                   skid_v_r;
  logic                   pop;
  logic                   push;

  assign in_tready = !skid_v_r;
  assign acc       = in_tvalid && in_tready;
  assign pop       = out_v_r && out_tready;
  assign push      = acc && emit;

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r + OFFSET_BITS'(1);
    start_nxt    = start_r;
    cnt_nxt      = cnt_r;
    len_nxt      = len_r;
    type_nxt     = type_r;
    crc_nxt      = crc_r;
    sig_good_nxt = sig_good_r;
    hdr_good_nxt = hdr_good_r;
    idat_nxt     = idat_r;
    iend_nxt     = iend_r;
    pending_nxt  = pending_r;
    mismatch_nxt = mismatch_r;
    emit         = 1'b0;
    res          = '0;

    case (phase_r)
      PH_SIG: begin
        mismatch_nxt = mismatch_r | (in_tdata != PNG_MAGIC[cnt_r[2:0]]);
        cnt_nxt      = cnt_r + 32'd1;
        if (cnt_r[2:0] == 3'd7) begin
          cnt_nxt = '0;
          if (mismatch_nxt) begin
            phase_nxt = PH_HALT;
          end else begin
            sig_good_nxt = 1'b1;
            phase_nxt    = PH_LEN;
          end
        end
      end
      PH_LEN: begin
        if (cnt_r == 32'd0) begin
          start_nxt = pos_r;
        end
        len_nxt = {len_r[23:0], in_tdata};
        cnt_nxt = cnt_r + 32'd1;
        if (cnt_r == 32'd3) begin
          cnt_nxt   = '0;
          phase_nxt = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_nxt = {type_r[23:0], in_tdata};
        cnt_nxt  = cnt_r + 32'd1;
        if (cnt_r == 32'd3) begin
          cnt_nxt = '0;
          if (pending_r && type_nxt != TAG_IHDR) begin
            phase_nxt = PH_HALT;
          end else begin
            if (pending_r) begin
              hdr_good_nxt = 1'b1;
              pending_nxt  = 1'b0;
            end
            if (len_r == 32'd0) begin
              phase_nxt = PH_CRC;
            end else begin
              cnt_nxt   = len_r;
              phase_nxt = PH_DATA;
            end
          end
        end
      end
      PH_DATA: begin
        cnt_nxt = cnt_r - 32'd1;
        if (cnt_r == 32'd1) begin
          phase_nxt = PH_CRC;
        end
      end
      PH_CRC: begin
        crc_nxt = {crc_r[23:0], in_tdata};
        cnt_nxt = cnt_r + 32'd1;
        if (cnt_r == 32'd3) begin
          cnt_nxt          = '0;
          res.chunk_kind   = kind_of(type_r);
          idat_nxt         = idat_r | (res.chunk_kind == KIND_IDAT);
          iend_nxt         = iend_r | (res.chunk_kind == KIND_IEND);
          res.chunk_offset = 32'(start_r);
          res.chunk_length = len_r;
          res.chunk_crc    = crc_nxt;
          emit             = 1'b1;
          phase_nxt        = PH_LEN;
        end
      end
      default: begin
      end
    endcase

    if (in_tlast) begin
      emit            = 1'b1;
      res.stream_done = 1'b1;
      case (phase_nxt)
        PH_SIG:  res.error_code = ERR_SIGNATURE;
        PH_LEN:  res.error_code = (cnt_nxt == 32'd0) ? ERR_NONE : ERR_TRUNCATED;
        PH_TYPE, PH_DATA, PH_CRC: res.error_code = ERR_TRUNCATED;
        default: res.error_code = sig_good_nxt ? ERR_HEADER : ERR_SIGNATURE;
      endcase
    end

    res.signature_good  = sig_good_nxt;
    res.header_good     = hdr_good_nxt;
    res.image_data_seen = idat_nxt;
    res.end_chunk_seen  = iend_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SIG;
      pos_r      <= '0;
      start_r    <= '0;
      cnt_r      <= '0;
      len_r      <= '0;
      type_r     <= '0;
      crc_r      <= '0;
      sig_good_r <= 1'b0;
      hdr_good_r <= 1'b0;
      idat_r     <= 1'b0;
      iend_r     <= 1'b0;
      pending_r  <= 1'b1;
      mismatch_r <= 1'b0;
      out_v_r    <= 1'b0;
      skid_v_r   <= 1'b0;
    end else begin
      if (acc) begin
        if (in_tlast) begin
          phase_r    <= PH_SIG;
          pos_r      <= '0;
          start_r    <= '0;
          cnt_r      <= '0;
          len_r      <= '0;
          type_r     <= '0;
          crc_r      <= '0;
          sig_good_r <= 1'b0;
          hdr_good_r <= 1'b0;
          idat_r     <= 1'b0;
          iend_r     <= 1'b0;
          pending_r  <= 1'b1;
          mismatch_r <= 1'b0;
        end else begin
          phase_r    <= phase_nxt;
          pos_r      <= pos_nxt;
          start_r    <= start_nxt;
          cnt_r      <= cnt_nxt;
          len_r      <= len_nxt;
          type_r     <= type_nxt;
          crc_r      <= crc_nxt;
          sig_good_r <= sig_good_nxt;
          hdr_good_r <= hdr_good_nxt;
          idat_r     <= idat_nxt;
          iend_r     <= iend_nxt;
          pending_r  <= pending_nxt;
          mismatch_r <= mismatch_nxt;
        end
      end
      if (!out_v_r || pop) begin
        if (skid_v_r) begin
          out_r    <= skid_r;
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end else begin
          out_r   <= res;
          out_v_r <= push;
        end
      end else if (push) begin
        skid_r   <= res;
        skid_v_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.chunk_kind;
  assign out_tlast  = out_r.stream_done;
  assign out_tdata  = {2'b00, out_r.error_code, out_r.end_chunk_seen,
                       out_r.image_data_seen, out_r.header_good,
                       out_r.signature_good, out_r.chunk_crc,
                       out_r.chunk_length, out_r.chunk_offset};

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held without an output entry");

  a_eof_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tlast) |=> (phase_r == PH_SIG && pos_r == '0 && pending_r))
    else $error("walk did not restart after the last byte");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && phase_r == PH_HALT && !in_tlast) |-> !emit)
    else $error("result produced while halted");

  a_chunk_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.chunk_kind != KIND_STATUS) |->
      (out_r.signature_good && out_r.header_good))
    else $error("chunk reported before a good signature and header");

endmodule
